[rtl/hvd_pkg.sv]
// Shared constants, types and the arctangent table for the haversine distance pipeline.
package hvd_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ANG_W        = 33;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int SQ_W         = 61;
    localparam int DIST_W       = 23;
    localparam int PIPE_DEPTH   = 100;

    localparam logic [26:0]              DEG2RAD_Q32 = 27'd74947179;
    localparam logic [32:0]              PI_Q30      = 33'd3373259426;
    localparam logic [32:0]              HALF_PI_Q30 = 33'd1686629713;
    localparam logic [32:0]              TWO_PI_Q30  = 33'd6746518852;
    localparam logic signed [ANG_W-1:0]  GAIN_INV    = 33'sd652032874;
    localparam logic [30:0]              Q30_ONE     = 31'h4000_0000;
    localparam logic [13:0]              DIAMETER_KM = 14'd12742;
    localparam logic [DIST_W-1:0]        DIST_MAX    = 23'd5124000;

    typedef logic [4:0] step_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sqrt_t;

    function automatic logic [ANG_W-1:0] atan_q30(input step_t i);
        logic [ANG_W-1:0] r;
        case (i)
            5'd0:    r = 33'h03243F6A8;
            5'd1:    r = 33'h01DAC6705;
            5'd2:    r = 33'h00FADBAFC;
            5'd3:    r = 33'h007F56EA6;
            5'd4:    r = 33'h003FEAB76;
            5'd5:    r = 33'h001FFD55B;
            5'd6:    r = 33'h000FFFAAA;
            5'd7:    r = 33'h0007FFF55;
            5'd8:    r = 33'h0003FFFEA;
            5'd9:    r = 33'h0001FFFFD;
            5'd10:   r = 33'h0000FFFFF;
            5'd11:   r = 33'h00007FFFF;
            5'd12:   r = 33'h00003FFFF;
            5'd13:   r = 33'h00001FFFF;
            5'd14:   r = 33'h00000FFFF;
            5'd15:   r = 33'h000007FFF;
            5'd16:   r = 33'h000003FFF;
            5'd17:   r = 33'h000001FFF;
            5'd18:   r = 33'h000000FFF;
            5'd19:   r = 33'h0000007FF;
            5'd20:   r = 33'h0000003FF;
            5'd21:   r = 33'h0000001FF;
            5'd22:   r = 33'h0000000FF;
            5'd23:   r = 33'h00000007F;
            5'd24:   r = 33'h00000003F;
            5'd25:   r = 33'h00000001F;
            5'd26:   r = 33'h00000000F;
            5'd27:   r = 33'h000000007;
            5'd28:   r = 33'h000000003;
            5'd29:   r = 33'h000000001;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/hvd_cordic_cell.sv]
// One registered CORDIC micro-rotation cell, usable in rotation or vectoring mode.
module hvd_cordic_cell (
    input  logic            clk,
    input  logic            en,
    input  logic            vectoring,
    input  hvd_pkg::step_t  step,
    input  hvd_pkg::cordic_t din,
    output hvd_pkg::cordic_t dout
);
    import hvd_pkg::*;

    logic signed [ANG_W-1:0] dx;
    logic signed [ANG_W-1:0] dy;
    logic signed [ANG_W-1:0] da;
    logic                    sub;
    cordic_t                 dout_next;
    cordic_t                 dout_reg;

    assign dx  = $signed(din.y) >>> step;
    assign dy  = $signed(din.x) >>> step;
    assign da  = $signed(atan_q30(step));
    assign sub = vectoring ? din.y[ANG_W-1] : !din.z[ANG_W-1];

    always_comb
    begin
        if (sub)
        begin
            dout_next.x = din.x - dx;
            dout_next.y = din.y + dy;
            dout_next.z = din.z - da;
        end
        else
        begin
            dout_next.x = din.x + dx;
            dout_next.y = din.y - dy;
            dout_next.z = din.z + da;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

[rtl/hvd_sqrt_cell.sv]
// One registered digit step of the integer square root.
module hvd_sqrt_cell (
    input  logic           clk,
    input  logic           en,
    input  hvd_pkg::step_t step,
    input  hvd_pkg::sqrt_t din,
    output hvd_pkg::sqrt_t dout
);
    import hvd_pkg::*;

    logic [5:0]      sh;
    logic [SQ_W-1:0] bit_val;
    logic [SQ_W:0]   trial;
    sqrt_t           dout_next;
    sqrt_t           dout_reg;

    assign sh      = 6'(2 * (SQRT_STEPS - 1)) - {step, 1'b0};
    assign bit_val = SQ_W'(1) << sh;
    assign trial   = {1'b0, din.root} + {1'b0, bit_val};

    always_comb
    begin
        if ({1'b0, din.rem} >= trial)
        begin
            dout_next.rem  = din.rem - trial[SQ_W-1:0];
            dout_next.root = (din.root >> 1) + bit_val;
        end
        else
        begin
            dout_next.rem  = din.rem;
            dout_next.root = din.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

[rtl/haversine_distance.sv]
// Top level of the pipelined haversine great-circle distance unit.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_stall    lat_a, lon_a, lat_b, lon_b
//   output    out_valid / out_stall  distance_km
//
// One transaction is taken per cycle while no valid output is stalled.
// The depth is set by four 30-cell sine/cosine CORDIC rows, two 31-cell square
// root rows and a 30-cell arctangent row, plus nine arithmetic stages.
// Reset clears only the valid bits of the pipeline.
// A stall on a valid output freezes the whole pipeline and stalls the input in the same cycle.
module haversine_distance (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] lat_a,
    input  logic signed [24:0] lon_a,
    input  logic signed [23:0] lat_b,
    input  logic signed [24:0] lon_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [22:0]        distance_km
);
    import hvd_pkg::*;

    logic                    adv;
    logic [PIPE_DEPTH-1:0]   vld_reg;
    logic [PIPE_DEPTH-1:0]   vld_next;

    logic signed [24:0]      dlat_s;
    logic signed [25:0]      dlon_s;
    logic [24:0]             mlat_next;
    logic [25:0]             mlon_next;
    logic [23:0]             mla_next;
    logic [23:0]             mlb_next;
    logic [24:0]             mlat_reg;
    logic [25:0]             mlon_reg;
    logic [23:0]             mla_reg;
    logic [23:0]             mlb_reg;

    logic [51:0]             plat;
    logic [52:0]             plon;
    logic [50:0]             pla;
    logic [50:0]             plb;
    logic [32:0]             hlat_reg;
    logic [32:0]             hlon_reg;
    logic [32:0]             ra_reg;
    logic [32:0]             rb_reg;

    logic [32:0]             ulat_next;
    logic [32:0]             ulon_next;
    logic [32:0]             ua_next;
    logic [32:0]             ub_next;
    logic [32:0]             ulat_reg;
    logic [32:0]             ulon_reg;
    logic [32:0]             ua_reg;
    logic [32:0]             ub_reg;

    logic [32:0]             zlat_next;
    logic [32:0]             zlon_next;
    logic [32:0]             za_next;
    logic [32:0]             zb_next;
    logic [1:0]              neg_next;
    logic [32:0]             zlat_reg;
    logic [32:0]             zlon_reg;
    logic [32:0]             za_reg;
    logic [32:0]             zb_reg;
    logic [1:0]              neg_reg;
    logic [1:0]              negp_reg [CORDIC_STEPS];

    cordic_t                 cor_w [4][CORDIC_STEPS+1];

    logic signed [ANG_W-1:0] ca_s;
    logic signed [ANG_W-1:0] cb_s;
    logic signed [65:0]      sqlat_p;
    logic signed [65:0]      sqlon_p;
    logic signed [65:0]      cc_p;
    logic signed [ANG_W-1:0] sqlat_reg;
    logic signed [ANG_W-1:0] sqlon_reg;
    logic signed [ANG_W-1:0] cc_reg;

    logic signed [65:0]      m_p;
    logic signed [ANG_W-1:0] m_reg;
    logic signed [ANG_W-1:0] sqlat2_reg;

    logic signed [ANG_W:0]   sum_s;
    logic [30:0]             a_next;
    logic [30:0]             a_reg;

    sqrt_t                   sq_w [2][SQRT_STEPS+1];
    cordic_t                 vec_w [CORDIC_STEPS+1];

    logic [30:0]             ang;
    logic [44:0]             prod_next;
    logic [44:0]             prod_reg;
    logic [45:0]             rnd;
    logic [23:0]             d_raw;
    logic [DIST_W-1:0]       dist_next;
    logic [DIST_W-1:0]       dist_reg;

    assign adv       = !(vld_reg[PIPE_DEPTH-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[PIPE_DEPTH-1];
    assign vld_next  = {vld_reg[PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Magnitudes of the differences and of the latitudes.
    always_comb
    begin
        dlat_s    = 25'(lat_a) - 25'(lat_b);
        dlon_s    = 26'(lon_a) - 26'(lon_b);
        mlat_next = dlat_s[24] ? 25'(-dlat_s) : 25'(dlat_s);
        mlon_next = dlon_s[25] ? 26'(-dlon_s) : 26'(dlon_s);
        mla_next  = lat_a[23] ? 24'(-lat_a) : 24'(lat_a);
        mlb_next  = lat_b[23] ? 24'(-lat_b) : 24'(lat_b);
    end

    // Degrees to radians; differences are halved on the way.
    assign plat = 52'(mlat_reg) * 52'(DEG2RAD_Q32);
    assign plon = 53'(mlon_reg) * 53'(DEG2RAD_Q32);
    assign pla  = 51'(mla_reg) * 51'(DEG2RAD_Q32);
    assign plb  = 51'(mlb_reg) * 51'(DEG2RAD_Q32);

    // Reduce the half differences modulo pi; a latitude above pi is reflected to two pi minus it.
    always_comb
    begin
        ulat_next = (hlat_reg >= PI_Q30) ? hlat_reg - PI_Q30 : hlat_reg;
        ulon_next = (hlon_reg >= PI_Q30) ? hlon_reg - PI_Q30 : hlon_reg;
        ua_next   = (ra_reg > PI_Q30) ? TWO_PI_Q30 - ra_reg : ra_reg;
        ub_next   = (rb_reg > PI_Q30) ? TWO_PI_Q30 - rb_reg : rb_reg;
    end

    // Fold into the first quadrant; a folded cosine changes sign.
    always_comb
    begin
        zlat_next   = (ulat_reg > HALF_PI_Q30) ? PI_Q30 - ulat_reg : ulat_reg;
        zlon_next   = (ulon_reg > HALF_PI_Q30) ? PI_Q30 - ulon_reg : ulon_reg;
        za_next     = (ua_reg > HALF_PI_Q30) ? PI_Q30 - ua_reg : ua_reg;
        zb_next     = (ub_reg > HALF_PI_Q30) ? PI_Q30 - ub_reg : ub_reg;
        neg_next[0] = ua_reg > HALF_PI_Q30;
        neg_next[1] = ub_reg > HALF_PI_Q30;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mlat_reg <= mlat_next;
            mlon_reg <= mlon_next;
            mla_reg  <= mla_next;
            mlb_reg  <= mlb_next;
            hlat_reg <= 33'(plat >> (FRAC_BITS + 3));
            hlon_reg <= 33'(plon >> (FRAC_BITS + 3));
            ra_reg   <= 33'(pla >> (FRAC_BITS + 2));
            rb_reg   <= 33'(plb >> (FRAC_BITS + 2));
            ulat_reg <= ulat_next;
            ulon_reg <= ulon_next;
            ua_reg   <= ua_next;
            ub_reg   <= ub_next;
            zlat_reg <= zlat_next;
            zlon_reg <= zlon_next;
            za_reg   <= za_next;
            zb_reg   <= zb_next;
            neg_reg  <= neg_next;
            negp_reg[0] <= neg_reg;
            for (int k = 1; k < CORDIC_STEPS; k++)
            begin
                negp_reg[k] <= negp_reg[k-1];
            end
        end
    end

    always_comb
    begin
        cor_w[0][0].x = GAIN_INV;
        cor_w[0][0].y = '0;
        cor_w[0][0].z = $signed(zlat_reg);
        cor_w[1][0].x = GAIN_INV;
        cor_w[1][0].y = '0;
        cor_w[1][0].z = $signed(zlon_reg);
        cor_w[2][0].x = GAIN_INV;
        cor_w[2][0].y = '0;
        cor_w[2][0].z = $signed(za_reg);
        cor_w[3][0].x = GAIN_INV;
        cor_w[3][0].y = '0;
        cor_w[3][0].z = $signed(zb_reg);
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_rot
        for (genvar k = 0; k < CORDIC_STEPS; k++)
        begin : g_cell
            hvd_cordic_cell u_cell (
                .clk       (clk),
                .en        (adv),
                .vectoring (1'b0),
                .step      (step_t'(k)),
                .din       (cor_w[l][k]),
                .dout      (cor_w[l][k+1])
            );
        end
    end

    // Squares of the sines and the cosine product.
    assign ca_s    = negp_reg[CORDIC_STEPS-1][0] ? -cor_w[2][CORDIC_STEPS].x
                                                 : cor_w[2][CORDIC_STEPS].x;
    assign cb_s    = negp_reg[CORDIC_STEPS-1][1] ? -cor_w[3][CORDIC_STEPS].x
                                                 : cor_w[3][CORDIC_STEPS].x;
    assign sqlat_p = $signed(cor_w[0][CORDIC_STEPS].y) * $signed(cor_w[0][CORDIC_STEPS].y);
    assign sqlon_p = $signed(cor_w[1][CORDIC_STEPS].y) * $signed(cor_w[1][CORDIC_STEPS].y);
    assign cc_p    = ca_s * cb_s;
    assign m_p     = cc_reg * sqlon_reg;
    assign sum_s   = (ANG_W+1)'(sqlat2_reg) + (ANG_W+1)'(m_reg);

    always_comb
    begin
        if (sum_s < 0)
        begin
            a_next = '0;
        end
        else if (sum_s > $signed({3'b000, Q30_ONE}))
        begin
            a_next = Q30_ONE;
        end
        else
        begin
            a_next = sum_s[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqlat_reg  <= ANG_W'(sqlat_p >>> 30);
            sqlon_reg  <= ANG_W'(sqlon_p >>> 30);
            cc_reg     <= ANG_W'(cc_p >>> 30);
            m_reg      <= ANG_W'(m_p >>> 30);
            sqlat2_reg <= sqlat_reg;
            a_reg      <= a_next;
        end
    end

    always_comb
    begin
        sq_w[0][0].rem  = {a_reg, 30'b0};
        sq_w[0][0].root = '0;
        sq_w[1][0].rem  = {Q30_ONE - a_reg, 30'b0};
        sq_w[1][0].root = '0;
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_sqrt
        for (genvar k = 0; k < SQRT_STEPS; k++)
        begin : g_cell
            hvd_sqrt_cell u_cell (
                .clk  (clk),
                .en   (adv),
                .step (step_t'(k)),
                .din  (sq_w[l][k]),
                .dout (sq_w[l][k+1])
            );
        end
    end

    always_comb
    begin
        vec_w[0].x = $signed(ANG_W'(sq_w[1][SQRT_STEPS].root[30:0]));
        vec_w[0].y = $signed(ANG_W'(sq_w[0][SQRT_STEPS].root[30:0]));
        vec_w[0].z = '0;
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_vec
        hvd_cordic_cell u_cell (
            .clk       (clk),
            .en        (adv),
            .vectoring (1'b1),
            .step      (step_t'(k)),
            .din       (vec_w[k]),
            .dout      (vec_w[k+1])
        );
    end

    // Central angle to distance, rounded and saturated.
    assign ang       = vec_w[CORDIC_STEPS].z[ANG_W-1] ? '0 : vec_w[CORDIC_STEPS].z[30:0];
    assign prod_next = 45'(ang) * 45'(DIAMETER_KM);
    assign rnd       = {1'b0, prod_reg} + 46'(1 << 21);
    assign d_raw     = rnd[45:22];
    assign dist_next = (d_raw > 24'(DIST_MAX)) ? DIST_MAX : d_raw[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            dist_reg <= dist_next;
        end
    end

    assign distance_km = dist_reg;

`ifndef SYNTHESIS
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance_km <= DIST_MAX)
        else $error("distance above saturation limit");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while output is blocked");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[PIPE_DEPTH-2] && !in_stall) |=> out_valid)
        else $error("result lost in last stage");
`endif

endmodule

[tb/tb_haversine_distance.sv]
// Self-checking testbench for the pipelined haversine great-circle distance unit.
`timescale 1ns / 100ps

module tb_haversine_distance;
    import hvd_pkg::*;

    localparam longint LAT_MAX = 5898240;
    localparam longint LON_MAX = 11796480;
    localparam longint Q1 = 64'sd1073741824;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_b;
    logic signed [24:0] lon_b;
    logic               out_valid;
    logic               out_stall;
    logic [22:0]        distance_km;

    logic [22:0] pending_dist[$];
    int          error_count;
    int          sent_count;
    int          recv_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    haversine_distance dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .lat_a       (lat_a),
        .lon_a       (lon_a),
        .lat_b       (lat_b),
        .lon_b       (lon_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .distance_km (distance_km)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_entry(int i);
        return longint'(atan_q30(step_t'(i)));
    endfunction

    function automatic void cordic_rotate(longint t, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = longint'(GAIN_INV);
        y = 0;
        z = t;
        for (int i = 0; i < 30; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_entry(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_entry(i);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint radians_of(longint deg, int extra);
        longint mag;
        mag = (deg < 0) ? -deg : deg;
        return longint'((longint'(unsigned'(mag)) * 64'd74947179) >> (16 + extra));
    endfunction

    function automatic longint half_sine_sq(longint h);
        longint t;
        longint c;
        longint s;
        t = h % 64'd3373259426;
        if (t > 64'd1686629713)
            t = 64'd3373259426 - t;
        cordic_rotate(t, c, s);
        return shr_floor(s * s, 30);
    endfunction

    function automatic longint cosine_of(longint r);
        longint t;
        longint c;
        longint s;
        bit     neg;
        neg = 1'b0;
        t = r % 64'd6746518852;
        if (t > 64'd3373259426)
            t = 64'd6746518852 - t;
        if (t > 64'd1686629713)
        begin
            t = 64'd3373259426 - t;
            neg = 1'b1;
        end
        cordic_rotate(t, c, s);
        return neg ? -c : c;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [22:0] great_circle_km(longint la, longint oa, longint lb, longint ob);
        longint s_lat;
        longint s_lon;
        longint ca;
        longint cb;
        longint hav;
        longint xs;
        longint ys;
        longint z;
        longint dx;
        longint dy;
        longint d;
        s_lat = half_sine_sq(radians_of(la - lb, 3));
        s_lon = half_sine_sq(radians_of(oa - ob, 3));
        ca = cosine_of(radians_of(la, 2));
        cb = cosine_of(radians_of(lb, 2));
        hav = s_lat + shr_floor(shr_floor(ca * cb, 30) * s_lon, 30);
        if (hav < 0)
            hav = 0;
        if (hav > Q1)
            hav = Q1;
        ys = int_sqrt(hav <<< 30);
        xs = int_sqrt((Q1 - hav) <<< 30);
        z = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = shr_floor(ys, i);
            dy = shr_floor(xs, i);
            if (ys >= 0)
            begin
                xs = xs + dx;
                ys = ys - dy;
                z = z + atan_entry(i);
            end
            else
            begin
                xs = xs - dx;
                ys = ys + dy;
                z = z - atan_entry(i);
            end
        end
        if (z < 0)
            z = 0;
        d = (z * 12742 + (64'sd1 <<< 21)) >>> 22;
        if (d > 5124000)
            d = 5124000;
        return d[22:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic send_pair(input logic [23:0] la, input logic [24:0] oa,
                             input logic [23:0] lb, input logic [24:0] ob);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        lat_a <= la;
        lon_a <= oa;
        lat_b <= lb;
        lon_b <= ob;
        pending_dist.push_back(great_circle_km(longint'($signed(la)), longint'($signed(oa)),
                                               longint'($signed(lb)), longint'($signed(ob))));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        go_idle();
        while (pending_dist.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        logic [22:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            recv_count++;
            if (pending_dist.size() == 0)
                report_mismatch($sformatf("unexpected distance %0d", distance_km));
            else
            begin
                want = pending_dist.pop_front();
                if (distance_km !== want)
                    report_mismatch($sformatf("distance_km got %0d expected %0d",
                                              distance_km, want));
            end
        end
    end

    function automatic longint rand_span(longint lim);
        return longint'($urandom_range(2 * lim)) - lim;
    endfunction

    task automatic test_directed();
        send_pair(0, 0, 0, 0);
        send_pair(24'(LAT_MAX), 0, 24'(-LAT_MAX), 0);
        send_pair(0, 25'(LON_MAX), 0, 25'(-LON_MAX));
        send_pair(0, 0, 0, 25'(LON_MAX));
        send_pair(24'(LAT_MAX), 25'(LON_MAX), 24'(LAT_MAX), 25'(-LON_MAX));
        send_pair(24'(-LAT_MAX), 0, 24'(-LAT_MAX), 25'(LON_MAX));
        send_pair(24'h7FFFFF, 25'h0FFFFFF, 24'h800000, 25'h1000000);
        send_pair(24'h800000, 25'h1000000, 24'h7FFFFF, 25'h0FFFFFF);
        send_pair(24'hFFFFFF, 25'h1FFFFFF, 24'h000001, 25'h0000001);
        send_pair(24'h7FFFFF, 0, 24'h7FFFFF, 25'(LON_MAX));
        send_pair(24'h700000, 0, 24'h100000, 25'h0800000);
        send_pair(24'(3 * 65536), 25'(5 * 65536), 24'(3 * 65536 + 1), 25'(5 * 65536));
        send_pair(0, 0, 0, 25'(LON_MAX - 1));
        send_pair(24'(LAT_MAX / 2), 25'(LON_MAX / 3), 24'(-LAT_MAX / 2), 25'(-LON_MAX / 2));
        send_pair(24'h555555, 25'h0AAAAAA, 24'hAAAAAA, 25'h1555555);
        drain();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                send_pair(24'($urandom), 25'($urandom), 24'($urandom), 25'($urandom));
            else
                send_pair(24'(rand_span(LAT_MAX)), 25'(rand_span(LON_MAX)),
                          24'(rand_span(LAT_MAX)), 25'(rand_span(LON_MAX)));
        end
    endtask

    task automatic test_hold_off();
        test_random(30);
        drain();
        test_random(30);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        lat_a = '0;
        lon_a = '0;
        lat_b = '0;
        lon_b = '0;
        error_count = 0;
        sent_count = 0;
        recv_count = 0;
        send_idle_pct = 21;
        recv_idle_pct = 60;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(200);
        send_idle_pct = 60;
        recv_idle_pct = 21;
        test_random(200);
        test_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(230);
        drain();
        repeat (150) @(posedge clk);
        $display("Sent %0d point pairs, checked %0d distances under three stall mixes.",
                 sent_count, recv_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/hvd_pkg.sv
rtl/hvd_cordic_cell.sv
rtl/hvd_sqrt_cell.sv
rtl/haversine_distance.sv
tb/tb_haversine_distance.sv
